// ----- rtl/core/sfc_pkg.sv -----
`timescale 1ns / 1ps
package sfc_pkg;

  localparam int ROUND_COUNT = 8;
  localparam int HALF_COUNT  = 2 * ROUND_COUNT;
  localparam int HALF_W      = (HALF_COUNT > 1) ? $clog2(HALF_COUNT) : 1;
  localparam int HALF_LAT    = 8;
  localparam int PIPE_LAT    = HALF_COUNT * HALF_LAT + 2;
  localparam int CNT_W       = $clog2(PIPE_LAT + 1);
  localparam int SBOX_DEPTH  = 512;
  localparam int SBOX_AW     = 9;
  localparam int LOOKUPS     = 11;

  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_ENCRYPT     = 2'd2;
  localparam logic [1:0] MODE_DECRYPT     = 2'd3;

  localparam logic CFG_LEFT_OFFSET  = 1'b0;
  localparam logic CFG_RIGHT_OFFSET = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        dec;
    logic [15:0] l;
    logic [15:0] r;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [SBOX_AW-1:0] addr;
    logic [7:0]         data;
  } wr_t;

endpackage

// ----- rtl/core/sbox_feistel_int32_cipher_unit.sv -----
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// request   start / busy            in_mode, in_table_index, in_table_value, in_data_word
// result    out_valid (strobe)      out_result_word
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word enters per cycle; each word passes an offset stage, eight stages per
// half-round and an exit stage before its result appears on out_result_word.
// Each half-round reads eleven private copies of the S-box RAM, all written together.
// A load is held off (busy) while any word is in flight; otherwise busy is low.
// Reset is synchronous and clears valid bits, the in-flight count and offsets.
module sbox_feistel_int32_cipher_unit
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_table_index,
  input  logic [7:0]  in_table_value,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  output logic [31:0] out_result_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] left_offset_r, right_offset_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic  accept, is_cipher;
  wr_t   wr;
  item_t entry_r, entry_nxt;
  item_t chain [0:HALF_COUNT];
  logic        out_valid_r;
  logic [31:0] out_result_word_r;

  assign is_cipher = in_mode == MODE_ENCRYPT || in_mode == MODE_DECRYPT;
  assign busy      = (cnt_r != '0) && !is_cipher;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    wr.en   = accept && !is_cipher;
    wr.addr = {in_mode == MODE_LOAD_SECOND, in_table_index};
    wr.data = in_table_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_offset_r  <= '0;
      right_offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LEFT_OFFSET) begin
        left_offset_r <= cfg_data;
      end else begin
        right_offset_r <= cfg_data;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && is_cipher) begin
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (out_valid_r) begin
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_comb begin
    entry_nxt.valid = accept && is_cipher;
    entry_nxt.dec   = in_mode == MODE_DECRYPT;
    if (entry_nxt.dec) begin
      entry_nxt.l = in_data_word[31:16];
      entry_nxt.r = in_data_word[15:0];
    end else begin
      entry_nxt.l = in_data_word[31:16] + left_offset_r;
      entry_nxt.r = in_data_word[15:0] + right_offset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      cnt_r         <= '0;
    end else begin
      entry_r <= entry_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign chain[0] = entry_r;

  genvar k;
  generate
    for (k = 0; k < HALF_COUNT; k++) begin : g_half
      sfc_half u_half (
        .clk      (clk),
        .rst_n    (rst_n),
        .half_idx (HALF_W'(k)),
        .wr       (wr),
        .in_item  (chain[k]),
        .out_item (chain[k+1])
      );
    end
  endgenerate

  // remove offsets after the last decryption round
  always_ff @(posedge clk) begin
    if (chain[HALF_COUNT].dec) begin
      out_result_word_r <= {chain[HALF_COUNT].l - left_offset_r,
                            chain[HALF_COUNT].r - right_offset_r};
    end else begin
      out_result_word_r <= {chain[HALF_COUNT].l, chain[HALF_COUNT].r};
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[HALF_COUNT].valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_result_word_r;

endmodule

// ----- rtl/core/sfc_ram.sv -----
`timescale 1ns / 1ps
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/sfc_half.sv -----
`timescale 1ns / 1ps
module sfc_half
  import sfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [HALF_W-1:0] half_idx,
  input  wr_t               wr,
  input  item_t             in_item,
  output item_t             out_item
);

  item_t item_r [1:7];
  item_t out_r;

  logic [SBOX_AW-1:0] raddr [0:LOOKUPS-1];
  logic [7:0]         rdata [0:LOOKUPS-1];

  logic [7:0] u1_3_r, u2_3_r;
  logic [7:0] u1_4_r, u2_4_r, bu2_4_r, bu1_4_r;
  logic [7:0] u1_5_r, u2_5_r, bu2_5_r, bu1_5_r, u3_5_r;
  logic [7:0] u1_6_r, u2_6_r, bu2_6_r, u3_6_r;
  logic [7:0] u1_7_r, ohi_7_r;

  logic [7:0] u1_c, u2_c, u3_c, u4_c, ohi_c, olo_c;
  logic [15:0] f_c, dst_c;
  item_t out_nxt;

  // table 0 is the first box, 1 the second; returns which one plays role a
  function automatic logic a_sel(input logic dec, input logic [HALF_W-1:0] k);
    a_sel = dec ^ ~k[0];
  endfunction

  function automatic logic [7:0] rnd_of(input logic dec, input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] step;
    step = k >> 1;
    if (dec) begin
      rnd_of = 8'(ROUND_COUNT - 1) - 8'(step);
    end else begin
      rnd_of = 8'(step);
    end
  endfunction

  function automatic logic [15:0] src_of(input item_t it, input logic [HALF_W-1:0] k);
    src_of = a_sel(it.dec, k) ? it.l : it.r;
  endfunction

  genvar g;
  generate
    for (g = 0; g < LOOKUPS; g++) begin : g_lk
      sfc_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr[g]),
        .rdata (rdata[g])
      );
    end
  endgenerate

  always_comb begin
    logic [15:0] x0, x1, x4;
    logic [7:0]  rn0, rn1, rn3, rn5;
    logic        as0, as1, as2, as3, as4, as5, as6;
    x0  = src_of(in_item, half_idx);
    x1  = src_of(item_r[1], half_idx);
    x4  = src_of(item_r[4], half_idx);
    rn0 = rnd_of(in_item.dec, half_idx);
    rn1 = rnd_of(item_r[1].dec, half_idx);
    rn3 = rnd_of(item_r[3].dec, half_idx);
    rn5 = rnd_of(item_r[5].dec, half_idx);
    as0 = a_sel(in_item.dec, half_idx);
    as1 = a_sel(item_r[1].dec, half_idx);
    as2 = a_sel(item_r[2].dec, half_idx);
    as3 = a_sel(item_r[3].dec, half_idx);
    as4 = a_sel(item_r[4].dec, half_idx);
    as5 = a_sel(item_r[5].dec, half_idx);
    as6 = a_sel(item_r[6].dec, half_idx);

    raddr[0] = {~as0, x0[15:8]};
    raddr[1] = {~as0, x0[7:0] ^ rn0};
    raddr[2] = {as1, x1[7:0] ^ rn1 ^ rdata[0]};
    raddr[3] = {as1, x1[15:8] ^ rn1 ^ rdata[1]};

    u1_c = rdata[2];
    u2_c = rdata[3] + rdata[2];
    raddr[4] = {~as2, u2_c};
    raddr[5] = {~as2, u1_c};

    raddr[6] = {as3, u1_3_r ^ rn3 ^ rdata[4]};

    u3_c = rdata[6] - x4[15:8];
    raddr[7] = {~as4, u3_c};

    raddr[8] = {as5, u2_5_r ^ rn5 ^ rdata[7]};
    raddr[9] = {as5, u3_5_r ^ bu1_5_r};

    u4_c  = rdata[8] + u3_6_r;
    ohi_c = rdata[9] ^ u2_6_r;
    raddr[10] = {as6, u4_c ^ bu2_6_r};

    olo_c = rdata[10] ^ u1_7_r;
    f_c   = {ohi_7_r, olo_c};
  end

  // even half-steps add into the destination half, odd ones subtract
  always_comb begin
    logic dst_is_r;
    dst_is_r = a_sel(item_r[7].dec, half_idx);
    out_nxt  = item_r[7];
    if (dst_is_r) begin
      dst_c = item_r[7].r;
    end else begin
      dst_c = item_r[7].l;
    end
    if (half_idx[0]) begin
      dst_c = dst_c - f_c;
    end else begin
      dst_c = dst_c + f_c;
    end
    if (dst_is_r) begin
      out_nxt.r = dst_c;
    end else begin
      out_nxt.l = dst_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 7; i++) begin
        item_r[i].valid <= 1'b0;
      end
      out_r.valid <= 1'b0;
    end else begin
      item_r[1] <= in_item;
      for (int i = 2; i <= 7; i++) begin
        item_r[i] <= item_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u1_3_r  <= u1_c;
    u2_3_r  <= u2_c;
    u1_4_r  <= u1_3_r;
    u2_4_r  <= u2_3_r;
    bu2_4_r <= rdata[4];
    bu1_4_r <= rdata[5];
    u1_5_r  <= u1_4_r;
    u2_5_r  <= u2_4_r;
    bu2_5_r <= bu2_4_r;
    bu1_5_r <= bu1_4_r;
    u3_5_r  <= u3_c;
    u1_6_r  <= u1_5_r;
    u2_6_r  <= u2_5_r;
    bu2_6_r <= bu2_5_r;
    u3_6_r  <= u3_5_r;
    u1_7_r  <= u1_6_r;
    ohi_7_r <= ohi_c;
  end

  assign out_item = out_r;

endmodule
